### src/assert_macros.svh
// Assertion macros shared by the button gesture recogniser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication checked on every rising edge of clk, off while in reset.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### src/bgr_pkg.sv
// Types and constants shared by the button gesture recogniser modules.
package bgr_pkg;

    localparam int LEVEL_W     = 4;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CODE_W      = 4;
    localparam int MAX_EV      = 4;
    localparam int CNT_W       = 3;
    localparam int POS_W       = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PRESSED,
        MODE_LONG,
        MODE_REPEAT
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;

    localparam logic [CFG_W-1:0] LONG_THRESHOLD_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] REPEAT_START_RST    = 16'd1500;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd200;

    localparam logic [CODE_W-1:0] EV_SHORT_UP        = 4'd0;
    localparam logic [CODE_W-1:0] EV_LONG_UP         = 4'd4;
    localparam logic [CODE_W-1:0] EV_COMBO_UP_DOWN   = 4'd8;
    localparam logic [CODE_W-1:0] EV_COMBO_UP_MENU   = 4'd9;
    localparam logic [CODE_W-1:0] EV_COMBO_DOWN_MENU = 4'd10;
    localparam logic [CODE_W-1:0] EV_REPEAT_UP       = 4'd11;
    localparam logic [CODE_W-1:0] EV_REPEAT_DOWN     = 4'd12;

    localparam logic [LEVEL_W-1:0] LV_UP   = 4'b0001;
    localparam logic [LEVEL_W-1:0] LV_DOWN = 4'b0010;

    typedef struct packed {
        logic [MAX_EV-1:0][CODE_W-1:0] codes;
        logic [CNT_W-1:0]              count;
        logic [TIME_W-1:0]             stamp;
    } ev_batch_t;

endpackage

### src/button_gesture_recognizer.sv
// Button gesture recogniser top level.
//
// s_tvalid/s_tready/s_tdata carry one request per debounced sample:
// button levels in bits 3:0 (up, down, menu, power), time in ms in 35:4.
// cfg_valid/cfg_index/cfg_data write long_threshold (0), repeat_start (1)
// and repeat_interval (2); cfg_ready is always high. Write only when idle.
// m_tvalid/m_tready/m_tdata/m_tlast carry gesture events: code in 3:0,
// time stamp in 35:4, tlast on the final event of a sample.
// The first event of a sample passes the input register, then the result
// register. Throughput: one sample per cycle while each makes at most one
// event and m_tready is high; a sample with more events (at most four) holds
// the result register until its last is sent. Eventless samples never hold it.
// Reset clears the gesture state to idle and restores the default
// thresholds. When the receiver stalls, the current event holds and one
// further sample waits in the input register before s_tready drops.
module button_gesture_recognizer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bgr_pkg::IN_TDATA_W-1:0]  s_tdata,   // button_levels, time_ms
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bgr_pkg::OUT_TDATA_W-1:0] m_tdata,   // event_code, event_time
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgr_pkg::CFG_W-1:0]       cfg_data
);
    import bgr_pkg::*;

    logic      can_load;
    logic      load;
    ev_batch_t batch;

    assign cfg_ready = 1'b1;

    bgr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .can_load  (can_load),
        .load      (load),
        .batch     (batch)
    );

    bgr_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .batch    (batch),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### src/bgr_core.sv
// Input register, gesture state and per-sample event list generation.
`include "assert_macros.svh"

module bgr_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bgr_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           cfg_valid,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgr_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           can_load,
    output logic                           load,
    output bgr_pkg::ev_batch_t             batch
);
    import bgr_pkg::*;

    logic [CFG_W-1:0]   long_thr_reg, rep_start_reg, rep_int_reg;
    logic               in_valid_reg;
    logic [LEVEL_W-1:0] lv_reg;
    logic [TIME_W-1:0]  t_reg;
    mode_t              mode_reg, mode_next;
    logic [LEVEL_W-1:0] prev_reg;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  last_rep_reg, last_rep_next;

    logic [LEVEL_W-1:0] pressed, released;
    mode_t              mode_a, mode_b, mode_c, mode_d;
    logic [TIME_W-1:0]  start_a, last_a, elapsed, rep_elapsed;
    logic               below_long, short_fire, long_fire, rep_enter, rep_due;
    logic               held, single_hit;
    logic [CODE_W-1:0]  single_code;

    function automatic logic combo_hit(input logic [LEVEL_W-1:0] lv);
        return ((lv & 4'b0011) == 4'b0011) || ((lv & 4'b0101) == 4'b0101) ||
               ((lv & 4'b0110) == 4'b0110);
    endfunction

    function automatic logic [CODE_W-1:0] combo_code(input logic [LEVEL_W-1:0] lv);
        logic [CODE_W-1:0] c;
        c = EV_COMBO_DOWN_MENU;
        if ((lv & 4'b0011) == 4'b0011)
            c = EV_COMBO_UP_DOWN;
        else if ((lv & 4'b0101) == 4'b0101)
            c = EV_COMBO_UP_MENU;
        return c;
    endfunction

    assign s_tready = !in_valid_reg || can_load;
    assign load     = in_valid_reg && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_thr_reg  <= LONG_THRESHOLD_RST;
            rep_start_reg <= REPEAT_START_RST;
            rep_int_reg   <= REPEAT_INTERVAL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LONG_THRESHOLD:  long_thr_reg  <= cfg_data;
                CFG_REPEAT_START:    rep_start_reg <= cfg_data;
                CFG_REPEAT_INTERVAL: rep_int_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            lv_reg <= s_tdata[LEVEL_W-1:0];
            t_reg  <= s_tdata[LEVEL_W +: TIME_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            prev_reg     <= '0;
            start_reg    <= '0;
            last_rep_reg <= '0;
        end
        else if (load)
        begin
            mode_reg     <= mode_next;
            prev_reg     <= lv_reg;
            start_reg    <= start_next;
            last_rep_reg <= last_rep_next;
        end
    end

    // mode progression through one sample: press, release, then hold checks
    always_comb
    begin
        pressed  = lv_reg & ~prev_reg;
        released = prev_reg & ~lv_reg;
        held     = lv_reg != '0;

        if (pressed != '0 && mode_reg == MODE_IDLE)
        begin
            start_a = t_reg;
            mode_a  = MODE_PRESSED;
        end
        else
        begin
            start_a = start_reg;
            mode_a  = mode_reg;
        end

        elapsed    = t_reg - start_a;
        below_long = elapsed < {{(TIME_W-CFG_W){1'b0}}, long_thr_reg};
        short_fire = released != '0 && mode_a == MODE_PRESSED && below_long;
        mode_b     = (released != '0 && prev_reg == released) ? MODE_IDLE : mode_a;

        unique case (lv_reg)
            4'b0001: begin single_hit = 1'b1; single_code = EV_LONG_UP;        end
            4'b0010: begin single_hit = 1'b1; single_code = EV_LONG_UP + 4'd1; end
            4'b0100: begin single_hit = 1'b1; single_code = EV_LONG_UP + 4'd2; end
            4'b1000: begin single_hit = 1'b1; single_code = EV_LONG_UP + 4'd3; end
            default: begin single_hit = 1'b0; single_code = EV_LONG_UP;        end
        endcase

        long_fire = held && mode_b == MODE_PRESSED && !below_long &&
                    (combo_hit(lv_reg) || single_hit);
        mode_c    = long_fire ? MODE_LONG : mode_b;

        rep_enter = held && mode_c == MODE_LONG &&
                    elapsed >= {{(TIME_W-CFG_W){1'b0}}, rep_start_reg};
        mode_d    = rep_enter ? MODE_REPEAT : mode_c;
        last_a    = rep_enter ? t_reg : last_rep_reg;

        rep_elapsed = t_reg - last_a;
        rep_due     = held && mode_d == MODE_REPEAT &&
                      rep_elapsed >= {{(TIME_W-CFG_W){1'b0}}, rep_int_reg} &&
                      (lv_reg == LV_UP || lv_reg == LV_DOWN);
    end

    always_comb
    begin
        mode_next     = mode_d;
        start_next    = start_a;
        last_rep_next = rep_due ? t_reg : last_a;
    end

    always_comb
    begin
        logic [CNT_W-1:0] n;
        n           = '0;
        batch.codes = '0;
        batch.stamp = t_reg;
        if (short_fire)
        begin
            if (combo_hit(prev_reg))
            begin
                batch.codes[0] = combo_code(prev_reg);
                n = 3'd1;
            end
            else
            begin
                for (int b = 0; b < LEVEL_W; b++)
                begin
                    if (released[b] && n < CNT_W'(MAX_EV))
                    begin
                        batch.codes[n[POS_W-1:0]] = EV_SHORT_UP + CODE_W'(b);
                        n = n + 3'd1;
                    end
                end
            end
        end
        if (long_fire && n < CNT_W'(MAX_EV))
        begin
            batch.codes[n[POS_W-1:0]] = combo_hit(lv_reg) ? combo_code(lv_reg) : single_code;
            n = n + 3'd1;
        end
        if (rep_due && n < CNT_W'(MAX_EV))
        begin
            batch.codes[n[POS_W-1:0]] = (lv_reg == LV_UP) ? EV_REPEAT_UP : EV_REPEAT_DOWN;
            n = n + 3'd1;
        end
        batch.count = n;
    end

    `ASSERT_IMPLY(a_idle_when_none_held, prev_reg == '0, mode_reg == MODE_IDLE,
                  "gesture mode not idle with no button held")

endmodule

### src/bgr_emit.sv
// Result register: holds one sample's events and sends them one per cycle while m_tready is high.
`include "assert_macros.svh"

module bgr_emit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  bgr_pkg::ev_batch_t              batch,
    output logic                            can_load,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bgr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import bgr_pkg::*;

    logic [MAX_EV-1:0][CODE_W-1:0] codes_reg;
    logic [TIME_W-1:0]             stamp_reg;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          is_last;

    assign m_tvalid = cnt_reg != '0;
    assign is_last  = {1'b0, pos_reg} == (cnt_reg - 3'd1);
    assign can_load = !m_tvalid || (m_tready && is_last);
    assign m_tlast  = is_last;
    assign m_tdata  = {{(OUT_TDATA_W-TIME_W-CODE_W){1'b0}}, stamp_reg, codes_reg[pos_reg]};

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (load)
        begin
            cnt_next = batch.count;
            pos_next = '0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (is_last)
                cnt_next = '0;
            else
                pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= batch.codes;
            stamp_reg <= batch.stamp;
        end
    end

    `ASSERT_CLK(a_cnt_range, cnt_reg <= CNT_W'(MAX_EV),
                "event count above four")
    `ASSERT_IMPLY(a_pos_in_range, m_tvalid, {1'b0, pos_reg} < cnt_reg,
                  "event pointer beyond loaded count")

endmodule
